// ===== hw/rtl/tdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared types and constants for the tapped delay channel: sample and tap
// setting formats, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package tdc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int PAIR_W      = 2 * SAMPLE_W;
   localparam int DELAY_W     = 6;
   localparam int SETTING_W   = PAIR_W + DELAY_W;
   localparam int ACTIVE_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int FRAC_W      = 15;
   localparam int ROUND_HALF  = 16384;
   localparam int SAT_MAX     = 32767;
   localparam int SAT_MIN     = -32768;
   localparam int NUM_TAP_REGS = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_TAPS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TAP0_SETTING = 3'd1;

   typedef struct packed {
      logic [DELAY_W-1:0]         delay;
      logic signed [SAMPLE_W-1:0] gain_im;
      logic signed [SAMPLE_W-1:0] gain_re;
   } tap_setting_type;

   localparam logic [ACTIVE_W-1:0] ACTIVE_TAPS_RESET = 3'd1;
   localparam tap_setting_type TAP0_RESET =
      '{delay: '0, gain_im: '0, gain_re: 16'sd32767};

endpackage

// ===== hw/rtl/tapped_delay_channel.sv =====
// ----------------------------------------------------------------------------
// tapped_delay_channel
// Stages A to D register in turn; each holds while the next is full and stalled.
// Throughput: one sample per clock unless stalled; one history RAM copy per tap.
// Reset clears the pipeline, the write position and the fill count, so the
// history reads as zero; active_taps returns to 1 and tap 0 to unit gain.
// ----------------------------------------------------------------------------
module tapped_delay_channel
   import tdc_pkg::*;
#(
   parameter int TAP_COUNT   = 4,
   parameter int DELAY_DEPTH = 64
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_re,
   input  logic signed [SAMPLE_W-1:0] req_sample_im,
   input  logic                       req_block_start,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_faded_re,
   output logic signed [SAMPLE_W-1:0] rsp_faded_im,
   output logic                       rsp_clipped,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [SETTING_W-1:0]       csr_wr_data
);

   localparam int AW  = $clog2(DELAY_DEPTH);
   localparam int CW  = (AW + 1 > DELAY_W) ? AW + 1 : DELAY_W;
   localparam int PW  = 2 * SAMPLE_W;
   localparam int TSW = PW + 1;
   localparam int ASW = TSW + $clog2(TAP_COUNT) + 1;

   // Configuration
   logic [ACTIVE_W-1:0] active_taps_ff;
   tap_setting_type     tap_ff [TAP_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_taps_ff <= ACTIVE_TAPS_RESET;
         for (int i = 0; i < TAP_COUNT; i++) begin
            tap_ff[i] <= (i == 0) ? TAP0_RESET : '0;
         end
      end else if (csr_wr_en) begin
         if (csr_index == REG_ACTIVE_TAPS) begin
            active_taps_ff <= csr_wr_data[ACTIVE_W-1:0];
         end
         for (int i = 0; i < TAP_COUNT; i++) begin
            if (i < NUM_TAP_REGS &&
                csr_index == REG_TAP0_SETTING + CSR_INDEX_W'(i)) begin
               tap_ff[i] <= tap_setting_type'(csr_wr_data);
            end
         end
      end
   end

   // Handshake chain
   logic va_ff, vb_ff, vc_ff, rsp_valid_ff;
   logic ready_a, ready_b, ready_c, ready_d;
   logic req_fire;

   assign ready_d   = !rsp_valid_ff || rsp_ready;
   assign ready_c   = !vc_ff || ready_d;
   assign ready_b   = !vb_ff || ready_c;
   assign ready_a   = !va_ff || ready_b;
   assign req_ready = ready_a;
   assign req_fire  = req_valid && ready_a;

   // Write position and fill count
   logic [AW-1:0]     wp_ff, wp_in, wp_use;
   logic [AW:0]       fill_ff, fill_in, fill_base;
   logic [PAIR_W-1:0] cur_sample;

   assign cur_sample = {req_sample_im, req_sample_re};
   assign wp_use     = req_block_start ? '0 : wp_ff;
   assign fill_base  = req_block_start ? '0 : fill_ff;
   assign fill_in    = (fill_base == (AW + 1)'(DELAY_DEPTH)) ? fill_base
                                                             : fill_base + 1'b1;
   assign wp_in      = (wp_use == AW'(DELAY_DEPTH - 1)) ? '0 : wp_use + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (req_fire) begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   // Stage A: history read per tap
   logic [AW-1:0]     rd_addr [TAP_COUNT];
   logic [CW-1:0]     delay_w [TAP_COUNT];
   logic [AW:0]       addr_sum [TAP_COUNT];
   logic [PAIR_W-1:0] ram_q [TAP_COUNT];
   logic [TAP_COUNT-1:0] use_in, zero_in, use_ff, zero_ff;
   logic [PAIR_W-1:0] cur_ff;

   always_comb begin
      for (int i = 0; i < TAP_COUNT; i++) begin
         delay_w[i]  = CW'(tap_ff[i].delay);
         use_in[i]   = (i < int'(active_taps_ff)) && (delay_w[i] < CW'(fill_in));
         zero_in[i]  = (tap_ff[i].delay == '0);
         addr_sum[i] = {1'b0, wp_use} + (AW + 1)'(DELAY_DEPTH)
                       - {1'b0, delay_w[i][AW-1:0]};
         if (addr_sum[i] >= (AW + 1)'(DELAY_DEPTH)) begin
            addr_sum[i] = addr_sum[i] - (AW + 1)'(DELAY_DEPTH);
         end
         rd_addr[i] = addr_sum[i][AW-1:0];
      end
   end

   for (genvar g = 0; g < TAP_COUNT; g++) begin : g_hist
      tdc_ram #(
         .WIDTH (PAIR_W),
         .DEPTH (DELAY_DEPTH)
      ) u_hist_ram (
         .clock   (clock),
         .wr_en   (req_fire),
         .wr_addr (wp_use),
         .wr_data (cur_sample),
         .rd_en   (ready_a),
         .rd_addr (rd_addr[g]),
         .rd_data (ram_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (ready_a) begin
         va_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         cur_ff  <= cur_sample;
         use_ff  <= use_in;
         zero_ff <= zero_in;
      end
   end

   // Stage B: complex products per tap
   logic [PAIR_W-1:0]      opnd [TAP_COUNT];
   logic signed [PW-1:0]   prr_in [TAP_COUNT], pii_in [TAP_COUNT];
   logic signed [PW-1:0]   pri_in [TAP_COUNT], pir_in [TAP_COUNT];
   logic signed [PW-1:0]   prr_ff [TAP_COUNT], pii_ff [TAP_COUNT];
   logic signed [PW-1:0]   pri_ff [TAP_COUNT], pir_ff [TAP_COUNT];

   always_comb begin
      for (int i = 0; i < TAP_COUNT; i++) begin
         if (!use_ff[i]) begin
            opnd[i] = '0;
         end else if (zero_ff[i]) begin
            opnd[i] = cur_ff;
         end else begin
            opnd[i] = ram_q[i];
         end
         prr_in[i] = tap_ff[i].gain_re * $signed(opnd[i][SAMPLE_W-1:0]);
         pii_in[i] = tap_ff[i].gain_im * $signed(opnd[i][PAIR_W-1:SAMPLE_W]);
         pri_in[i] = tap_ff[i].gain_re * $signed(opnd[i][PAIR_W-1:SAMPLE_W]);
         pir_in[i] = tap_ff[i].gain_im * $signed(opnd[i][SAMPLE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (ready_b) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         prr_ff <= prr_in;
         pii_ff <= pii_in;
         pri_ff <= pri_in;
         pir_ff <= pir_in;
      end
   end

   // Stage C: per-tap complex sums
   logic signed [TSW-1:0] tre_in [TAP_COUNT], tim_in [TAP_COUNT];
   logic signed [TSW-1:0] tre_ff [TAP_COUNT], tim_ff [TAP_COUNT];

   always_comb begin
      for (int i = 0; i < TAP_COUNT; i++) begin
         tre_in[i] = TSW'(prr_ff[i]) - TSW'(pii_ff[i]);
         tim_in[i] = TSW'(pri_ff[i]) + TSW'(pir_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (ready_c) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_c) begin
         tre_ff <= tre_in;
         tim_ff <= tim_in;
      end
   end

   // Stage D: accumulate, round and saturate
   logic signed [ASW-1:0] acc_re, acc_im;
   logic signed [ASW:0]   rnd_re, rnd_im, sh_re, sh_im;
   logic signed [SAMPLE_W-1:0] faded_re_in, faded_im_in;
   logic clip_re, clip_im;
   logic signed [SAMPLE_W-1:0] faded_re_ff, faded_im_ff;
   logic clipped_ff;

   always_comb begin
      acc_re = '0;
      acc_im = '0;
      for (int i = 0; i < TAP_COUNT; i++) begin
         acc_re = acc_re + ASW'(tre_ff[i]);
         acc_im = acc_im + ASW'(tim_ff[i]);
      end
      rnd_re = (ASW + 1)'(acc_re) + (ASW + 1)'(ROUND_HALF);
      rnd_im = (ASW + 1)'(acc_im) + (ASW + 1)'(ROUND_HALF);
      sh_re  = rnd_re >>> FRAC_W;
      sh_im  = rnd_im >>> FRAC_W;
      clip_re = 1'b0;
      clip_im = 1'b0;
      priority if (sh_re > (ASW + 1)'(SAT_MAX)) begin
         faded_re_in = SAMPLE_W'(SAT_MAX);
         clip_re     = 1'b1;
      end else if (sh_re < (ASW + 1)'(SAT_MIN)) begin
         faded_re_in = SAMPLE_W'(SAT_MIN);
         clip_re     = 1'b1;
      end else begin
         faded_re_in = sh_re[SAMPLE_W-1:0];
      end
      priority if (sh_im > (ASW + 1)'(SAT_MAX)) begin
         faded_im_in = SAMPLE_W'(SAT_MAX);
         clip_im     = 1'b1;
      end else if (sh_im < (ASW + 1)'(SAT_MIN)) begin
         faded_im_in = SAMPLE_W'(SAT_MIN);
         clip_im     = 1'b1;
      end else begin
         faded_im_in = sh_im[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready_d) begin
         rsp_valid_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_d) begin
         faded_re_ff <= faded_re_in;
         faded_im_ff <= faded_im_in;
         clipped_ff  <= clip_re || clip_im;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_faded_re = faded_re_ff;
   assign rsp_faded_im = faded_im_ff;
   assign rsp_clipped  = clipped_ff;

   // Assertions
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (AW + 1)'(DELAY_DEPTH))
      else $error("History fill count exceeds the delay depth.");

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff < AW'(DELAY_DEPTH - 1) || wp_ff == AW'(DELAY_DEPTH - 1))
      else $error("Write position is outside the history line.");

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_block_start |=> fill_ff == (AW + 1)'(1) && wp_ff == AW'(1))
      else $error("Block start did not restart the history line.");

   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_faded_re == SAMPLE_W'(SAT_MAX) || rsp_faded_re == SAMPLE_W'(SAT_MIN) ||
         rsp_faded_im == SAMPLE_W'(SAT_MAX) || rsp_faded_im == SAMPLE_W'(SAT_MIN))
      else $error("Clipped result does not sit at a saturation rail.");

endmodule

// ===== hw/rtl/tdc_ram.sv =====
// ----------------------------------------------------------------------------
// tdc_ram
// Generic single-write, single-read RAM with a registered read port that
// holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module tdc_ram
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
)
(
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/tapped_delay_channel_tb.sv =====
// ----------------------------------------------------------------------------
// tapped_delay_channel_tb
// Self-checking testbench for the tapped delay channel. A behavioral channel
// model mirrors every register write and predicts each faded sample from
// every accepted input transfer. Directed tests cover extremes, saturation
// and odd tap counts. Random tests then run blocks of samples under several
// idle and stall patterns, and a long receiver hold-off that back-pressures
// the input.
// ----------------------------------------------------------------------------
module tapped_delay_channel_tb;
   import tdc_pkg::*;

   localparam int HIST_DEPTH = 64;
   localparam int NUM_TAPS   = 4;

   typedef struct {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic                       clip;
   } faded_sample_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_re = '0;
   logic signed [SAMPLE_W-1:0] req_sample_im = '0;
   logic                       req_block_start = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_faded_re;
   logic signed [SAMPLE_W-1:0] rsp_faded_im;
   logic                       rsp_clipped;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [SETTING_W-1:0]       csr_wr_data = '0;

   logic [PAIR_W-1:0]   chan_history [HIST_DEPTH];
   logic [DELAY_W-1:0]  chan_wr_pos;
   logic [ACTIVE_W-1:0] chan_active;
   tap_setting_type     chan_taps [NUM_TAPS];

   faded_sample_type expected_faded [$];
   int            mismatch_count = 0;
   int            tx_idle_pct = 0;
   int            rx_stall_pct = 0;
   int            rx_hold_cycles = 0;
   int            block_left = 0;

   tapped_delay_channel dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_re   (req_sample_re),
      .req_sample_im   (req_sample_im),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_faded_re    (rsp_faded_re),
      .rsp_faded_im    (rsp_faded_im),
      .rsp_clipped     (rsp_clipped),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (rx_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      faded_sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_faded.size() == 0) begin
            $display("%0t: unexpected transfer: re %0d im %0d clipped %0b",
                     $time, rsp_faded_re, rsp_faded_im, rsp_clipped);
            mismatch_count++;
         end else begin
            want = expected_faded.pop_front();
            if (rsp_faded_re !== want.re) begin
               $display("%0t: faded_re expected %0d, actual %0d",
                        $time, want.re, rsp_faded_re);
               mismatch_count++;
            end
            if (rsp_faded_im !== want.im) begin
               $display("%0t: faded_im expected %0d, actual %0d",
                        $time, want.im, rsp_faded_im);
               mismatch_count++;
            end
            if (rsp_clipped !== want.clip) begin
               $display("%0t: clipped expected %0b, actual %0b",
                        $time, want.clip, rsp_clipped);
               mismatch_count++;
            end
         end
      end
   end

   task automatic reset_channel_model();
      foreach (chan_history[i]) chan_history[i] = '0;
      chan_wr_pos = '0;
      chan_active = ACTIVE_TAPS_RESET;
      foreach (chan_taps[i]) chan_taps[i] = '0;
      chan_taps[0] = TAP0_RESET;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] saturate(input longint v,
                                                           inout logic clip);
      if (v > SAT_MAX) begin
         clip = 1'b1;
         return SAMPLE_W'(SAT_MAX);
      end
      if (v < SAT_MIN) begin
         clip = 1'b1;
         return SAMPLE_W'(SAT_MIN);
      end
      return SAMPLE_W'(v);
   endfunction

   task automatic predict_faded(input logic signed [SAMPLE_W-1:0] re,
                                input logic signed [SAMPLE_W-1:0] im,
                                input logic block_start);
      longint             acc_re;
      longint             acc_im;
      longint             gr;
      longint             gi;
      longint             xr;
      longint             xi;
      logic [DELAY_W-1:0] pos;
      logic [PAIR_W-1:0]  h;
      faded_sample_type   result;
      acc_re = 0;
      acc_im = 0;
      result.clip = 1'b0;
      if (block_start) begin
         foreach (chan_history[i]) chan_history[i] = '0;
         chan_wr_pos = '0;
      end
      chan_history[chan_wr_pos] = {im, re};
      for (int k = 0; k < NUM_TAPS; k++) begin
         if (k < chan_active) begin
            pos = chan_wr_pos - chan_taps[k].delay;
            h = chan_history[pos];
            gr = $signed(chan_taps[k].gain_re);
            gi = $signed(chan_taps[k].gain_im);
            xr = $signed(h[SAMPLE_W-1:0]);
            xi = $signed(h[PAIR_W-1:SAMPLE_W]);
            acc_re += gr * xr - gi * xi;
            acc_im += gr * xi + gi * xr;
         end
      end
      chan_wr_pos = chan_wr_pos + 1'b1;
      result.re = saturate((acc_re + ROUND_HALF) >>> FRAC_W, result.clip);
      result.im = saturate((acc_im + ROUND_HALF) >>> FRAC_W, result.clip);
      expected_faded.push_back(result);
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] re,
                              input logic signed [SAMPLE_W-1:0] im,
                              input logic block_start);
      int gap;
      gap = 0;
      while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_re   <= re;
      req_sample_im   <= im;
      req_block_start <= block_start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_faded(re, im, block_start);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_faded.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [SETTING_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      if (idx == REG_ACTIVE_TAPS) begin
         chan_active = data[ACTIVE_W-1:0];
      end else if (idx >= REG_TAP0_SETTING && idx < REG_TAP0_SETTING + NUM_TAP_REGS) begin
         chan_taps[idx - REG_TAP0_SETTING] = data;
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_tap(input int k, input logic [SAMPLE_W-1:0] gain_re,
                          input logic [SAMPLE_W-1:0] gain_im,
                          input logic [DELAY_W-1:0] delay);
      write_reg(CSR_INDEX_W'(REG_TAP0_SETTING + k), {delay, gain_im, gain_re});
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_gain();
      logic signed [SAMPLE_W-1:0] g;
      g = SAMPLE_W'($urandom);
      case ($urandom_range(0, 3))
         0: return g;
         1: return g >>> 3;
         2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         default: return SAMPLE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         1: return SAMPLE_W'($urandom_range(0, 3));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic random_config();
      int n;
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      write_reg(REG_ACTIVE_TAPS, SETTING_W'(n));
      for (int k = 0; k < NUM_TAPS; k++) begin
         set_tap(k, pick_gain(), pick_gain(),
                 $urandom_range(0, 1) ? DELAY_W'($urandom_range(0, 7))
                                      : DELAY_W'($urandom_range(0, 63)));
      end
   endtask

   task automatic send_random_sample();
      logic start;
      if (block_left == 0 && $urandom_range(99) < 85) begin
         start = 1'b1;
         block_left = $urandom_range(1, 100);
      end else begin
         start = (block_left == 0) && ($urandom_range(19) == 0);
      end
      if (block_left > 0) block_left--;
      send_sample(pick_sample(), pick_sample(), start);
   endtask

   task automatic test_reset_defaults();
      send_sample(16'sh7fff, 16'sh8000, 1'b1);
      send_sample(16'sh8000, 16'sh7fff, 1'b0);
      send_sample(16'sd0, 16'sd0, 1'b0);
      send_sample(16'sd1, -16'sd1, 1'b0);
      send_sample(-16'sd1, 16'sd1, 1'b0);
      send_sample(16'sd16384, -16'sd16384, 1'b0);
      drain();
   endtask

   task automatic test_tap_extremes();
      write_reg(REG_ACTIVE_TAPS, SETTING_W'(NUM_TAPS));
      set_tap(0, 16'h8000, 16'h0000, 6'd0);
      set_tap(1, 16'h7fff, 16'h8000, 6'd63);
      set_tap(2, 16'h0000, 16'h7fff, 6'd1);
      set_tap(3, 16'h8000, 16'h8000, 6'd1);
      for (int idx = REG_TAP0_SETTING + NUM_TAP_REGS; idx < 2 ** CSR_INDEX_W; idx++) begin
         write_reg(CSR_INDEX_W'(idx), SETTING_W'({$urandom, $urandom}));
      end
      send_sample(16'sh7fff, 16'sh8000, 1'b1);
      send_sample(16'sh8000, 16'sh8000, 1'b0);
      send_sample(16'sh7fff, 16'sh7fff, 1'b0);
      send_sample(16'sh1234, -16'sh4321, 1'b1);
      drain();
   endtask

   task automatic test_active_count_edges();
      write_reg(REG_ACTIVE_TAPS, '0);
      send_sample(16'sh7fff, 16'sh7fff, 1'b0);
      send_sample(16'sh8000, 16'sh8000, 1'b0);
      drain();
      write_reg(REG_ACTIVE_TAPS, SETTING_W'(2 ** ACTIVE_W - 1));
      send_sample(16'sh4000, -16'sh2000, 1'b0);
      send_sample(-16'sh7000, 16'sh0100, 1'b0);
      drain();
   endtask

   task automatic test_saturation();
      write_reg(REG_ACTIVE_TAPS, SETTING_W'(NUM_TAPS));
      for (int k = 0; k < NUM_TAPS; k++) set_tap(k, 16'h8000, 16'h0000, 6'd0);
      send_sample(16'sh8000, 16'sh8000, 1'b1);
      send_sample(16'sh7fff, 16'sh8000, 1'b0);
      send_sample(16'sh8000, 16'sh7fff, 1'b0);
      drain();
   endtask

   task automatic test_random_traffic();
      int tx_pct [4] = '{0, 67, 0, 17};
      int rx_pct [4] = '{0, 0, 67, 17};
      for (int phase = 0; phase < 4; phase++) begin
         tx_idle_pct  = tx_pct[phase];
         rx_stall_pct = rx_pct[phase];
         repeat (3) begin
            random_config();
            repeat (70) send_random_sample();
            drain();
         end
      end
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      random_config();
      tx_idle_pct    = 0;
      rx_stall_pct   = 0;
      rx_hold_cycles = 200;
      repeat (60) send_random_sample();
      drain();
   endtask

   initial begin
      reset_channel_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_tap_extremes();
      test_active_count_edges();
      test_saturation();
      test_random_traffic();
      test_backpressure();
      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== tapped_delay_channel.f =====
hw/rtl/tdc_pkg.sv
hw/rtl/tdc_ram.sv
hw/rtl/tapped_delay_channel.sv
dv/tapped_delay_channel_tb.sv
